### design/ffba_pkg.sv
package ffba_pkg;

  // Pool geometry.
  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 32;

  // Derived widths. A run length or pointer needs one bit more than a block index.
  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int SIZE_W = 16;
  localparam int OFF_W  = 11;
  localparam int ERR_W  = 2;
  localparam int USED_W = 7;

  localparam logic [ERR_W-1:0] ERR_NONE          = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OUT_OF_MEMORY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_FIT        = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  free_offset;
  } in_t;

  typedef struct packed {
    logic              granted;
    logic [OFF_W-1:0]  alloc_offset;
    logic [ERR_W-1:0]  error_code;
    logic [USED_W-1:0] used_count;
  } out_t;

  // Access request from the sequencer to the block map.
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
  } map_req_t;

endpackage

### design/ffba_ram.sv
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/ffba_map.sv
module ffba_map (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ffba_pkg::map_req_t       req_i,
  output logic [ffba_pkg::CNT_W-1:0] rd_data_o
);
  import ffba_pkg::*;

  // One valid flag per entry stands in for clearing the RAM at reset.
  logic [NUM_BLOCKS-1:0] valid_q;
  logic                  rd_valid_q;
  logic [CNT_W-1:0]      ram_rd_data;

  ffba_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.wr_addr),
    .wr_data_i (req_i.wr_data),
    .rd_addr_i (req_i.rd_addr),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.rd_addr];
    end
  end

  // An entry never written since reset reads as free.
  assign rd_data_o = rd_valid_q ? ram_rd_data : '0;

endmodule

### design/first_fit_block_allocator_core.sv
// First-fit block allocator over a pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes.
// Requests arrive on the input channel (in_valid_i / in_stall_o); a transfer
// happens on a clock edge with valid high and stall low. Each request yields
// exactly one result on the output channel (out_valid_o / out_stall_i).
// An allocate rounds its size up to a block count and scans the block map from
// block 0, one entry per cycle through the map RAM's registered read port, for
// the first free run of that length; it then marks the run one entry per cycle.
// A free reads the run length at its block and clears that many entries one per
// cycle, stopping at the end of the map.
// Only one request is in flight; in_stall_o stays high until the result has
// been loaded into the output register, so the next request can be taken while
// a finished result still waits for the receiver. A new request is therefore
// taken only once the previous result has reached the output register.
// A stalled result holds its value until it is taken.
// Reset clears the used tally and the per-entry valid flags, so the whole map
// reads as free right after reset; no clearing pass is needed.
module first_fit_block_allocator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffba_pkg::in_t  in_payload_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ffba_pkg::out_t out_payload_o
);
  import ffba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FCLR = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic             res_grant_q, res_grant_d;
  logic [ERR_W-1:0] res_err_q, res_err_d;
  logic [OFF_W-1:0] res_off_q, res_off_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  map_req_t         map_req;
  logic [CNT_W-1:0] map_rd_data;

  logic [SIZE_W:0]  size_sum;
  logic [SIZE_W:0]  req_count;
  logic [OFF_W-1:0] free_idx;
  logic [CNT_W-1:0] run_next;
  logic [CNT_W:0]   used_sum;
  logic             in_xfer;
  logic             out_free;

  ffba_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (map_rd_data)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Block count of an allocate; the divisor is a constant.
  assign size_sum  = {1'b0, in_payload_i.size_bytes} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign req_count = (SIZE_W + 1)'(size_sum / BLOCK_BYTES);
  assign free_idx  = OFF_W'(in_payload_i.free_offset / BLOCK_BYTES);

  // The scan step unit: run length after the entry that just came back.
  assign run_next = (map_rd_data == '0) ? run_q + CNT_W'(1) : '0;
  assign used_sum = {1'b0, used_q} + {1'b0, count_q};

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    run_d       = run_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    start_d     = start_q;
    res_grant_d = res_grant_q;
    res_err_d   = res_err_q;
    res_off_d   = res_off_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    map_req         = '0;
    map_req.rd_addr = rd_idx_q[IDX_W-1:0];
    map_req.wr_addr = ptr_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        map_req.rd_addr = free_idx[IDX_W-1:0];
        if (in_xfer) begin
          res_grant_d = 1'b0;
          res_err_d   = ERR_NONE;
          res_off_d   = '0;
          if (in_payload_i.req_type == REQ_ALLOC) begin
            if (in_payload_i.size_bytes == '0) begin
              res_err_d = ERR_NO_FIT;
              state_d   = S_OUT;
            end else if (used_q >= CNT_W'(NUM_BLOCKS)) begin
              res_err_d = ERR_OUT_OF_MEMORY;
              state_d   = S_OUT;
            end else if (req_count > (SIZE_W + 1)'(NUM_BLOCKS)) begin
              res_err_d = ERR_NO_FIT;
              state_d   = S_OUT;
            end else begin
              count_d  = CNT_W'(req_count);
              rd_idx_d = '0;
              pend_d   = 1'b0;
              run_d    = '0;
              state_d  = S_SCAN;
            end
          end else begin
            if (free_idx >= OFF_W'(NUM_BLOCKS)) begin
              state_d = S_OUT;
            end else begin
              ptr_d   = CNT_W'(free_idx);
              state_d = S_FRD;
            end
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while checking the entry read last cycle.
        if (rd_idx_q < CNT_W'(NUM_BLOCKS)) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
          pend_d   = 1'b1;
          pidx_d   = rd_idx_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          run_d = run_next;
          if (run_next == count_q) begin
            start_d = IDX_W'({1'b0, pidx_q} + CNT_W'(1) - count_q);
            ptr_d   = {1'b0, pidx_q} + CNT_W'(1) - count_q;
            rem_d   = count_q;
            state_d = S_MARK;
          end
        end else if (rd_idx_q >= CNT_W'(NUM_BLOCKS)) begin
          res_err_d = ERR_NO_FIT;
          state_d   = S_OUT;
        end
      end

      S_MARK: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_data = count_q;
        ptr_d           = ptr_q + CNT_W'(1);
        rem_d           = rem_q - CNT_W'(1);
        if (rem_q == CNT_W'(1)) begin
          used_d      = (used_sum > (CNT_W + 1)'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                              : CNT_W'(used_sum);
          res_grant_d = 1'b1;
          res_off_d   = OFF_W'(32'(start_q) * 32'(BLOCK_BYTES));
          state_d     = S_OUT;
        end
      end

      S_FRD: begin
        // The run length at the freed block is on the read port now.
        used_d      = (used_q > map_rd_data) ? used_q - map_rd_data : '0;
        rem_d       = map_rd_data;
        res_grant_d = 1'b1;
        if (map_rd_data == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_FCLR;
        end
      end

      S_FCLR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_data = '0;
        ptr_d           = ptr_q + CNT_W'(1);
        rem_d           = rem_q - CNT_W'(1);
        if (rem_q == CNT_W'(1) || ptr_q + CNT_W'(1) >= CNT_W'(NUM_BLOCKS)) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.granted      = res_grant_q;
          out_d.alloc_offset = res_off_q;
          out_d.error_code   = res_err_q;
          out_d.used_count   = USED_W'(used_q);
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    rd_idx_q    <= rd_idx_d;
    pidx_q      <= pidx_d;
    run_q       <= run_d;
    ptr_q       <= ptr_d;
    rem_q       <= rem_d;
    start_q     <= start_d;
    res_grant_q <= res_grant_d;
    res_err_q   <= res_err_d;
    res_off_q   <= res_off_d;
    out_q       <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

  // The used tally never exceeds the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(NUM_BLOCKS))
    else $error("used tally above pool size");

  // A marking or clearing walk always has entries left to visit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK || state_q == S_FCLR) |-> rem_q != '0)
    else $error("walk with no entries left");

  // During a scan the checked entry trails the issued read by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> ({1'b0, pidx_q} + CNT_W'(1) == rd_idx_q))
    else $error("scan read pipeline out of step");

  // A granted result never carries an error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.granted) |-> out_q.error_code == ERR_NONE)
    else $error("granted result with error code");

endmodule

### tb/first_fit_block_allocator_core_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_core_test;
  import ffba_pkg::*;

  // The scoreboard keeps its own copy of the block map and the used tally.
  // Every accepted request is run through that copy right away, and the
  // answer it gives is queued until the matching result transfer comes out.
  class alloc_scoreboard;
    logic [CNT_W-1:0] block_map [NUM_BLOCKS];
    bit               run_head [NUM_BLOCKS];
    int unsigned      used_blocks;
    out_t             expected_q [$];
    int               errors;

    function new();
      foreach (block_map[i]) begin
        block_map[i] = '0;
        run_head[i]  = 1'b0;
      end
      used_blocks = 0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Returns the index of a block where some live allocation begins, or -1
    // when nothing is allocated. The stimulus uses it to free real runs.
    function int random_run_head();
      int heads [$];
      foreach (run_head[i]) begin
        if (run_head[i]) heads.push_back(i);
      end
      if (heads.size() == 0) return -1;
      return heads[$urandom_range(heads.size() - 1)];
    endfunction

    // Applies one request to the local map and queues the answer it yields.
    function void note_request(in_t req);
      out_t res;
      int   count;
      int   run;
      int   start;
      int   idx;
      int   len;
      bit   found;
      res   = '0;
      found = 1'b0;
      start = 0;
      run   = 0;
      if (req.req_type == REQ_ALLOC) begin
        if (req.size_bytes == '0) begin
          res.error_code = ERR_NO_FIT;
        end else if (used_blocks >= NUM_BLOCKS) begin
          res.error_code = ERR_OUT_OF_MEMORY;
        end else begin
          count = (int'(req.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
          // First fit: scan from block 0 for the first free run that is long enough.
          if (count <= NUM_BLOCKS) begin
            for (int i = 0; i < NUM_BLOCKS && !found; i++) begin
              run = (block_map[i] == '0) ? run + 1 : 0;
              if (run == count) begin
                start = i + 1 - count;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            res.error_code = ERR_NO_FIT;
          end else begin
            for (int i = start; i < start + count; i++) begin
              block_map[i] = CNT_W'(count);
              run_head[i]  = 1'b0;
            end
            run_head[start]  = 1'b1;
            used_blocks      = used_blocks + count;
            if (used_blocks > NUM_BLOCKS) used_blocks = NUM_BLOCKS;
            res.granted      = 1'b1;
            res.alloc_offset = OFF_W'(start * BLOCK_BYTES);
          end
        end
      end else begin
        idx = int'(req.free_offset) / BLOCK_BYTES;
        if (idx < NUM_BLOCKS) begin
          // The stored length is trusted as given, even in the middle of a
          // run, and the tally is clamped at zero when it drifts.
          len         = int'(block_map[idx]);
          used_blocks = (used_blocks > len) ? used_blocks - len : 0;
          for (int i = idx; i < idx + len && i < NUM_BLOCKS; i++) begin
            block_map[i] = '0;
            run_head[i]  = 1'b0;
          end
          res.granted = 1'b1;
        end
      end
      res.used_count = USED_W'(used_blocks);
      expected_q.push_back(res);
    endfunction

    function void field_mismatch(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      field_mismatch("granted", 16'(want.granted), 16'(got.granted));
      field_mismatch("alloc_offset", 16'(want.alloc_offset), 16'(got.alloc_offset));
      field_mismatch("error_code", 16'(want.error_code), 16'(got.error_code));
      field_mismatch("used_count", 16'(want.used_count), 16'(got.used_count));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i   = 1'b0;
  logic in_stall_o;
  in_t  in_payload_i = '0;
  logic out_valid_o;
  logic out_stall_i  = 1'b0;
  out_t out_payload_o;

  alloc_scoreboard sb;

  // Receiver bookkeeping: results taken so far and the remaining length of
  // the one long hold-off.
  int  results_taken = 0;
  int  hold_left     = 0;
  bit  held_once     = 1'b0;

  always #2 clk_i = ~clk_i;

  first_fit_block_allocator_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_payload_i (in_payload_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_payload_o(out_payload_o)
  );

  // Receiver side. A result transfer is checked at the edge where it
  // happens; then the stall for the next cycle is chosen. After 150 results
  // the receiver holds off once, long enough that the output register fills
  // and the block stalls its input. Between results 520 and 680, which
  // covers the stretch where the sender offers without gaps, it never
  // stalls at all.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(out_payload_o);
      results_taken++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (results_taken == 150 && !held_once) begin
      held_once = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else if (results_taken >= 520 && results_taken < 680) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 31);
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  // The scoreboard is updated at that same edge.
  task automatic send_request(in_t req);
    in_valid_i   <= 1'b1;
    in_payload_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // Idles the input channel until every queued result has come out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // The field that a request type ignores still gets random content, so
  // every input bit toggles.
  function automatic in_t make_req(logic kind, int size, int offset);
    in_t r;
    r.req_type    = kind;
    r.size_bytes  = (kind == REQ_ALLOC) ? SIZE_W'(size) : SIZE_W'($urandom);
    r.free_offset = (kind == REQ_FREE) ? OFF_W'(offset) : OFF_W'($urandom);
    return r;
  endfunction

  // Mostly well-formed traffic: allocations of modest size and frees of live
  // runs at any byte inside their first block. The rest is noise: frees at
  // random offsets, zero sizes and full-range sizes.
  function automatic in_t random_request();
    int pick;
    int head;
    int size;
    pick = $urandom_range(99);
    head = sb.random_run_head();
    if (pick < 48) begin
      size = $urandom_range(99);
      if (size < 70) size = $urandom_range(256, 1);
      else if (size < 95) size = $urandom_range(NUM_BLOCKS * BLOCK_BYTES, 1);
      else size = $urandom_range(65535);
      return make_req(REQ_ALLOC, size, 0);
    end else if (pick < 90 && head >= 0) begin
      return make_req(REQ_FREE, 0, head * BLOCK_BYTES + $urandom_range(BLOCK_BYTES - 1));
    end else if (pick < 95) begin
      return make_req(REQ_FREE, 0, $urandom_range(2047));
    end else if (pick < 97) begin
      return make_req(REQ_ALLOC, 0, 0);
    end
    return make_req(REQ_ALLOC, $urandom_range(65535), 0);
  endfunction

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Rejections first: zero size, the largest size, and a
    // size one byte past the whole pool.
    send_request(make_req(REQ_ALLOC, 0, 0));
    send_request(make_req(REQ_ALLOC, 65535, 0));
    send_request(make_req(REQ_ALLOC, NUM_BLOCKS * BLOCK_BYTES + 1, 0));
    // Small runs packed from block 0, with rounding at a block boundary.
    send_request(make_req(REQ_ALLOC, 1, 0));
    send_request(make_req(REQ_ALLOC, 32, 0));
    send_request(make_req(REQ_ALLOC, 33, 0));
    send_request(make_req(REQ_ALLOC, 96, 0));
    // Free a run, then free the same block again while it is free.
    send_request(make_req(REQ_FREE, 0, 32 + 5));
    send_request(make_req(REQ_FREE, 0, 32));
    // First fit must reuse the hole at block 1.
    send_request(make_req(REQ_ALLOC, 2, 0));
    // Free from the second block of a two-block run; the tally drifts.
    send_request(make_req(REQ_FREE, 0, 3 * BLOCK_BYTES));
    // A whole-pool request cannot fit while anything is held.
    send_request(make_req(REQ_ALLOC, NUM_BLOCKS * BLOCK_BYTES, 0));
    send_request(make_req(REQ_FREE, 0, 0));
    send_request(make_req(REQ_FREE, 0, 1 * BLOCK_BYTES));
    send_request(make_req(REQ_FREE, 0, 2 * BLOCK_BYTES));
    send_request(make_req(REQ_FREE, 0, 5 * BLOCK_BYTES));
    // Take the whole pool, then hit the full-pool rejection.
    send_request(make_req(REQ_ALLOC, NUM_BLOCKS * BLOCK_BYTES, 0));
    send_request(make_req(REQ_ALLOC, 1, 0));
    // Free from the last byte of the pool: the clear stops at the map's end,
    // which leaves exactly the last block free for the next allocation.
    send_request(make_req(REQ_FREE, 0, 2047));
    send_request(make_req(REQ_ALLOC, 1, 0));
    send_request(make_req(REQ_FREE, 0, 0));
    send_request(make_req(REQ_FREE, 0, (NUM_BLOCKS - 1) * BLOCK_BYTES));
    send_request(make_req(REQ_ALLOC, 65535, 0));
    wait_for_drain();

    // Random part. At item 300 the sender pauses until the block has
    // answered everything; items 500 to 649 go out without gaps.
    for (int n = 0; n < 950; n++) begin
      if (n == 300) wait_for_drain();
      if (n < 500 || n >= 650) begin
        while ($urandom_range(99) < 31) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      send_request(random_request());
    end
    in_valid_i <= 1'b0;

    // Let any stray result show up after the last expected one.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * NUM_BLOCKS + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // The slowest correct run, about a thousand requests plus stalls and gaps,
  // ends well before the watchdog fires.
  initial begin : watchdog
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
